[hw/rtl/accel_scheduled_gain_macros.svh]
// ----------------------------------------------------------------------------
// accel_scheduled_gain assertion macros
// clocked assertion helpers used by accel_scheduled_gain.sv
// ----------------------------------------------------------------------------
`ifndef ACCEL_SCHEDULED_GAIN_MACROS_SVH
`define ACCEL_SCHEDULED_GAIN_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASG_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define ASG_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/asg_pkg.sv]
// ----------------------------------------------------------------------------
// asg_pkg
// shared types and constants of the acceleration scheduled gain block
// ----------------------------------------------------------------------------
package asg_pkg;

	// divider sizes
	localparam int DIV_DVD_W = 48;
	localparam int DIV_DSR_W = 32;
	localparam int DIV_CNT_W = $clog2(DIV_DVD_W);

	// square root sizes
	localparam int SQ_RAD_W  = 64;
	localparam int SQ_ROOT_W = SQ_RAD_W / 2;
	localparam int SQ_CNT_W  = $clog2(SQ_ROOT_W);

	localparam logic [31:0] US_PER_S = 32'd1000000;
	localparam logic [16:0] ONE_Q16  = 17'h10000;

	// register indexes
	localparam logic [2:0] REG_GAIN_FLOOR   = 3'd0;
	localparam logic [2:0] REG_GAIN_CEILING = 3'd1;
	localparam logic [2:0] REG_LOW_THRESH   = 3'd2;
	localparam logic [2:0] REG_HIGH_THRESH  = 3'd3;
	localparam logic [2:0] REG_ACCEL_LIMIT  = 3'd4;
	localparam logic [2:0] REG_FILT_WEIGHT  = 3'd5;

	// status of an iterative unit
	typedef struct packed {
		logic busy;
		logic done;
	} asg_unit_sts_t;

endpackage

[hw/rtl/asg_div.sv]
// ----------------------------------------------------------------------------
// asg_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module asg_div (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic [asg_pkg::DIV_DVD_W-1:0]        dividend,
	input  logic [asg_pkg::DIV_DSR_W-1:0]        divisor,
	output asg_pkg::asg_unit_sts_t               sts,
	output logic [asg_pkg::DIV_DVD_W-1:0]        quotient
);
	import asg_pkg::*;

	logic                 run_q, done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_DVD_W-1:0] dvd_q;
	logic [DIV_DSR_W-1:0] rem_q, dsr_q;
	logic [DIV_DSR_W:0]   rem_sh;
	logic [DIV_DSR_W+1:0] diff;
	logic                 ge;

	always_comb begin
		rem_sh = {rem_q, dvd_q[DIV_DVD_W-1]};
		diff   = {1'b0, rem_sh} - {2'b00, dsr_q};
		ge     = !diff[DIV_DSR_W+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_DVD_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// quotient bits shift in where dividend bits leave
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (run_q) begin
			rem_q <= ge ? diff[DIV_DSR_W-1:0] : rem_sh[DIV_DSR_W-1:0];
			dvd_q <= {dvd_q[DIV_DVD_W-2:0], ge};
		end
	end

	assign sts.busy = run_q;
	assign sts.done = done_q;
	assign quotient = dvd_q;

endmodule

[hw/rtl/asg_isqrt.sv]
// ----------------------------------------------------------------------------
// asg_isqrt
// digit by digit integer square root, one root bit per cycle
// ----------------------------------------------------------------------------
module asg_isqrt (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic [asg_pkg::SQ_RAD_W-1:0]         radicand,
	output asg_pkg::asg_unit_sts_t               sts,
	output logic [asg_pkg::SQ_ROOT_W-1:0]        root
);
	import asg_pkg::*;

	logic                  run_q, done_q;
	logic [SQ_CNT_W-1:0]   cnt_q;
	logic [SQ_RAD_W-1:0]   rad_q;
	logic [SQ_ROOT_W-1:0]  root_q;
	logic [SQ_ROOT_W+1:0]  rem_q;
	logic [SQ_ROOT_W+3:0]  rem_sh, trial, diff;
	logic                  ge;

	always_comb begin
		rem_sh = {rem_q, rad_q[SQ_RAD_W-1:SQ_RAD_W-2]};
		trial  = {2'b00, root_q, 2'b01};
		ge     = rem_sh >= trial;
		diff   = rem_sh - trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == SQ_CNT_W'(SQ_ROOT_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			root_q <= '0;
			rem_q  <= '0;
		end else if (run_q) begin
			rad_q  <= {rad_q[SQ_RAD_W-3:0], 2'b00};
			rem_q  <= ge ? diff[SQ_ROOT_W+1:0] : rem_sh[SQ_ROOT_W+1:0];
			root_q <= {root_q[SQ_ROOT_W-2:0], ge};
		end
	end

	assign sts.busy = run_q;
	assign sts.done = done_q;
	assign root     = root_q;

endmodule

[hw/rtl/accel_scheduled_gain.sv]
// ----------------------------------------------------------------------------
// accel_scheduled_gain
// acceleration scheduled gain: differentiate, limit, filter, smoothstep gain
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid / in_stall) carries func, vel_x, vel_y, step_us.
//   output channel (out_valid / out_stall) carries ok, gain, accel_x, accel_y.
//   config channel (cfg_valid / cfg_ready, cfg_index, cfg_data) writes the six
//   registers; cfg_ready is always high, indexes above five are dropped.
//   one item is worked at a time: in_stall is high from the accepting edge
//   until the result sits in the output register.
//   a restart gives no transaction; a zero step goes straight to the output.
//   the first sample after restart skips differentiation and limiting; later
//   samples run up to two 48-step divides per axis pass (differentiate,
//   limit) plus two 32-step square roots and one more divide for the gain
//   ramp, all sequenced over one shared multiplier, divider and root unit.
//   a waiting result holds while out_stall is high; the block then holds
//   its finished item and takes no new one until the output is free.
//   reset returns registers to their defaults and clears the filter state.
// ----------------------------------------------------------------------------
`include "accel_scheduled_gain_macros.svh"

module accel_scheduled_gain (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               func,
	input  logic signed [15:0] vel_x,
	input  logic signed [15:0] vel_y,
	input  logic [19:0]        step_us,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               ok,
	output logic [15:0]        gain,
	output logic signed [16:0] accel_x,
	output logic signed [16:0] accel_y,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [16:0]        cfg_data
);
	import asg_pkg::*;

	typedef enum logic [28:0] {
		ST_IDLE     = 29'h0000001,
		ST_DV_MUL   = 29'h0000002,
		ST_DV_DIV   = 29'h0000004,
		ST_DV_WAIT  = 29'h0000008,
		ST_SHIFT    = 29'h0000010,
		ST_SQ_X     = 29'h0000020,
		ST_SQ_Y     = 29'h0000040,
		ST_SQ_LIM   = 29'h0000080,
		ST_CMP      = 29'h0000100,
		ST_LSQ_WAIT = 29'h0000200,
		ST_SC_MUL   = 29'h0000400,
		ST_SC_DIV   = 29'h0000800,
		ST_SC_WAIT  = 29'h0001000,
		ST_F_MUL    = 29'h0002000,
		ST_F_ADD    = 29'h0004000,
		ST_N_X      = 29'h0008000,
		ST_N_Y      = 29'h0010000,
		ST_N_SUM    = 29'h0020000,
		ST_NSQ_WAIT = 29'h0040000,
		ST_N_RSQ    = 29'h0080000,
		ST_N_RND    = 29'h0100000,
		ST_AL_DIV   = 29'h0200000,
		ST_AL_WAIT  = 29'h0400000,
		ST_SM_A2    = 29'h0800000,
		ST_SM_K     = 29'h1000000,
		ST_SM_RND   = 29'h2000000,
		ST_GN_MUL   = 29'h4000000,
		ST_GN_ADD   = 29'h8000000,
		ST_FIN      = 29'h10000000
	} state_t;

	state_t state_q;

	// configuration
	logic [15:0] floor_q, ceil_q, lo_q, hi_q, lim_q;
	logic [16:0] wt_q;

	// persistent state
	logic signed [15:0] lvx_q, lvy_q;
	logic signed [16:0] fx_q, fy_q;
	logic               primed_q;

	// working registers
	logic signed [15:0] vx_q, vy_q;
	logic [19:0]        dt_q;
	logic               axis_q, over_q, dsgn_q, ok_res_q;
	logic [1:0]         sgn_q;
	logic [35:0]        ax_q, ay_q;
	logic [63:0]        sum_q, prod_q;
	logic [31:0]        r_q;
	logic [16:0]        alpha_q, smooth_q;
	logic [15:0]        gain_res_q;

	// output register
	logic               out_valid_q, ok_q;
	logic [15:0]        gain_q;
	logic signed [16:0] acc_x_q, acc_y_q;

	// shared units
	logic [31:0]            op_a, op_b;
	logic                   div_start, sq_start;
	logic [DIV_DVD_W-1:0]   div_dvd, div_quot;
	logic [DIV_DSR_W-1:0]   div_dsr;
	logic [SQ_RAD_W-1:0]    sq_rad;
	logic [SQ_ROOT_W-1:0]   sq_root;
	asg_unit_sts_t          div_sts, sq_sts;

	logic               in_acc, out_free;
	logic signed [16:0] dv;
	logic [16:0]        dv_mag;
	logic [16:0]        a_sel;
	logic signed [16:0] f_sel;
	logic signed [17:0] rx, fdiff;
	logic [17:0]        dmag;
	logic [16:0]        weff;
	logic [35:0]        qround;
	logic signed [19:0] fsum;
	logic signed [16:0] fsat;
	logic [16:0]        fx_mag, fy_mag;
	logic [15:0]        width, t;
	logic [31:0]        rd;
	logic               thr_ord;
	logic signed [16:0] span;
	logic [15:0]        span_mag;
	logic [32:0]        gq;
	logic [63:0]        sm_round;
	logic [17:0]        kfac;

	assign in_acc   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign cfg_ready = 1'b1;

	always_comb begin
		dv     = axis_q ? (17'(vy_q) - 17'(lvy_q)) : (17'(vx_q) - 17'(lvx_q));
		dv_mag = dv[16] ? 17'(-dv) : 17'(dv);
		a_sel  = axis_q ? ay_q[16:0] : ax_q[16:0];
		f_sel  = axis_q ? fy_q : fx_q;
		rx     = sgn_q[axis_q] ? -$signed({1'b0, a_sel}) : $signed({1'b0, a_sel});
		fdiff  = rx - 18'(f_sel);
		dmag   = fdiff[17] ? 18'(-fdiff) : 18'(fdiff);
		weff   = wt_q[16] ? ONE_Q16 : wt_q;
		qround = prod_q[35:0] + 36'h8000;
		fsum   = dsgn_q ? (20'(f_sel) - $signed({2'b00, qround[33:16]}))
		                : (20'(f_sel) + $signed({2'b00, qround[33:16]}));
		if (fsum > 20'sd65535)
			fsat = 17'sh0FFFF;
		else if (fsum < -20'sd65536)
			fsat = 17'sh10000;
		else
			fsat = fsum[16:0];
		fx_mag  = fx_q[16] ? 17'(-fx_q) : 17'(fx_q);
		fy_mag  = fy_q[16] ? 17'(-fy_q) : 17'(fy_q);
		thr_ord = hi_q > lo_q;
		width   = hi_q - lo_q;
		rd      = r_q - {16'b0, lo_q};
		if (r_q <= {16'b0, lo_q})
			t = '0;
		else if (rd > {16'b0, width})
			t = width;
		else
			t = rd[15:0];
		kfac     = 18'h30000 - {alpha_q, 1'b0};
		sm_round = prod_q + 64'h8000_0000;
		span     = $signed({1'b0, ceil_q}) - $signed({1'b0, floor_q});
		span_mag = span[16] ? 16'(-span) : span[15:0];
		gq       = prod_q[32:0] + 33'h8000;
	end

	// shared multiplier operand select
	always_comb begin
		op_a = '0;
		op_b = '0;
		case (state_q)
			ST_DV_MUL: begin
				op_a = {15'b0, dv_mag};
				op_b = US_PER_S;
			end
			ST_SQ_X: begin
				op_a = ax_q[31:0];
				op_b = ax_q[31:0];
			end
			ST_SQ_Y: begin
				op_a = ay_q[31:0];
				op_b = ay_q[31:0];
			end
			ST_SQ_LIM: begin
				op_a = {16'b0, lim_q};
				op_b = {16'b0, lim_q};
			end
			ST_SC_MUL: begin
				op_a = axis_q ? ay_q[31:0] : ax_q[31:0];
				op_b = {16'b0, lim_q};
			end
			ST_F_MUL: begin
				op_a = {15'b0, weff};
				op_b = {14'b0, dmag};
			end
			ST_N_X: begin
				op_a = {15'b0, fx_mag};
				op_b = {15'b0, fx_mag};
			end
			ST_N_Y: begin
				op_a = {15'b0, fy_mag};
				op_b = {15'b0, fy_mag};
			end
			ST_N_RSQ: begin
				op_a = r_q;
				op_b = r_q;
			end
			ST_SM_A2: begin
				op_a = {15'b0, alpha_q};
				op_b = {15'b0, alpha_q};
			end
			ST_SM_K: begin
				op_a = prod_q[31:0];
				op_b = {14'b0, kfac};
			end
			ST_GN_MUL: begin
				op_a = {15'b0, smooth_q};
				op_b = {16'b0, span_mag};
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= op_a * op_b;
	end

	// divider and root operand select
	always_comb begin
		div_start = 1'b0;
		div_dvd   = '0;
		div_dsr   = '0;
		case (state_q)
			ST_DV_DIV: begin
				div_start = 1'b1;
				div_dvd   = prod_q[47:0] + {29'b0, dt_q[19:1]};
				div_dsr   = {12'b0, dt_q};
			end
			ST_SC_DIV: begin
				div_start = 1'b1;
				div_dvd   = prod_q[47:0] + {17'b0, r_q[31:1]};
				div_dsr   = r_q;
			end
			ST_AL_DIV: begin
				div_start = thr_ord;
				div_dvd   = {16'b0, t, 16'b0} + {33'b0, width[15:1]};
				div_dsr   = {16'b0, width};
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	assign sq_start = ((state_q == ST_CMP) && (over_q || (sum_q > prod_q)))
	                  || (state_q == ST_N_SUM);
	assign sq_rad   = (state_q == ST_N_SUM) ? (sum_q + prod_q) : sum_q;

	asg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dsr),
		.sts      (div_sts),
		.quotient (div_quot)
	);

	asg_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (sq_rad),
		.sts      (sq_sts),
		.root     (sq_root)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			floor_q <= 16'd4096;
			ceil_q  <= 16'd4096;
			lo_q    <= 16'd256;
			hi_q    <= 16'd768;
			lim_q   <= 16'd2560;
			wt_q    <= ONE_Q16;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_GAIN_FLOOR:   floor_q <= cfg_data[15:0];
				REG_GAIN_CEILING: ceil_q  <= cfg_data[15:0];
				REG_LOW_THRESH:   lo_q    <= cfg_data[15:0];
				REG_HIGH_THRESH:  hi_q    <= cfg_data[15:0];
				REG_ACCEL_LIMIT:  lim_q   <= cfg_data[15:0];
				REG_FILT_WEIGHT:  wt_q    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			primed_q    <= 1'b0;
			lvx_q       <= '0;
			lvy_q       <= '0;
			fx_q        <= '0;
			fy_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_FIN && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (func) begin
							lvx_q    <= '0;
							lvy_q    <= '0;
							fx_q     <= '0;
							fy_q     <= '0;
							primed_q <= 1'b0;
						end else if (step_us == '0) begin
							state_q <= ST_FIN;
						end else if (!primed_q) begin
							lvx_q    <= vel_x;
							lvy_q    <= vel_y;
							fx_q     <= '0;
							fy_q     <= '0;
							primed_q <= 1'b1;
							state_q  <= ST_N_X;
						end else begin
							state_q <= ST_DV_MUL;
						end
					end
				end
				ST_DV_MUL:  state_q <= ST_DV_DIV;
				ST_DV_DIV:  state_q <= ST_DV_WAIT;
				ST_DV_WAIT: begin
					if (div_sts.done)
						state_q <= axis_q ? ST_SHIFT : ST_DV_MUL;
				end
				ST_SHIFT: begin
					if (ax_q[35:31] == '0 && ay_q[35:31] == '0)
						state_q <= ST_SQ_X;
				end
				ST_SQ_X:   state_q <= ST_SQ_Y;
				ST_SQ_Y:   state_q <= ST_SQ_LIM;
				ST_SQ_LIM: state_q <= ST_CMP;
				ST_CMP:    state_q <= sq_start ? ST_LSQ_WAIT : ST_F_MUL;
				ST_LSQ_WAIT: begin
					if (sq_sts.done)
						state_q <= (sq_root == '0) ? ST_F_MUL : ST_SC_MUL;
				end
				ST_SC_MUL: state_q <= ST_SC_DIV;
				ST_SC_DIV: state_q <= ST_SC_WAIT;
				ST_SC_WAIT: begin
					if (div_sts.done)
						state_q <= axis_q ? ST_F_MUL : ST_SC_MUL;
				end
				ST_F_MUL: state_q <= ST_F_ADD;
				ST_F_ADD: begin
					if (axis_q) begin
						fy_q    <= fsat;
						lvx_q   <= vx_q;
						lvy_q   <= vy_q;
						state_q <= ST_N_X;
					end else begin
						fx_q    <= fsat;
						state_q <= ST_F_MUL;
					end
				end
				ST_N_X:   state_q <= ST_N_Y;
				ST_N_Y:   state_q <= ST_N_SUM;
				ST_N_SUM: state_q <= ST_NSQ_WAIT;
				ST_NSQ_WAIT: begin
					if (sq_sts.done)
						state_q <= ST_N_RSQ;
				end
				ST_N_RSQ:  state_q <= ST_N_RND;
				ST_N_RND:  state_q <= ST_AL_DIV;
				ST_AL_DIV: state_q <= thr_ord ? ST_AL_WAIT : ST_SM_A2;
				ST_AL_WAIT: begin
					if (div_sts.done)
						state_q <= ST_SM_A2;
				end
				ST_SM_A2:  state_q <= ST_SM_K;
				ST_SM_K:   state_q <= ST_SM_RND;
				ST_SM_RND: state_q <= ST_GN_MUL;
				ST_GN_MUL: state_q <= ST_GN_ADD;
				ST_GN_ADD: state_q <= ST_FIN;
				ST_FIN: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				vx_q     <= vel_x;
				vy_q     <= vel_y;
				dt_q     <= step_us;
				ok_res_q <= (step_us != '0);
				axis_q   <= 1'b0;
				over_q   <= 1'b0;
			end
			ST_DV_MUL: sgn_q[axis_q] <= dv[16];
			ST_DV_WAIT: begin
				if (div_sts.done) begin
					if (axis_q)
						ay_q <= div_quot[35:0];
					else
						ax_q <= div_quot[35:0];
					axis_q <= !axis_q;
				end
			end
			ST_SHIFT: begin
				if (ax_q[35:31] != '0 || ay_q[35:31] != '0) begin
					ax_q   <= ax_q >> 1;
					ay_q   <= ay_q >> 1;
					over_q <= 1'b1;
				end
			end
			ST_SQ_Y:   sum_q <= prod_q;
			ST_SQ_LIM: sum_q <= sum_q + prod_q;
			ST_LSQ_WAIT: begin
				if (sq_sts.done) begin
					r_q <= sq_root;
					if (sq_root == '0) begin
						ax_q <= '0;
						ay_q <= '0;
					end
				end
			end
			ST_SC_WAIT: begin
				if (div_sts.done) begin
					if (axis_q)
						ay_q <= div_quot[35:0];
					else
						ax_q <= div_quot[35:0];
					axis_q <= !axis_q;
				end
			end
			ST_F_MUL: dsgn_q <= fdiff[17];
			ST_F_ADD: axis_q <= !axis_q;
			ST_N_Y:   sum_q  <= prod_q;
			ST_N_SUM: sum_q  <= sum_q + prod_q;
			ST_NSQ_WAIT: begin
				if (sq_sts.done)
					r_q <= sq_root;
			end
			// round the floor root to nearest
			ST_N_RND: begin
				if ((sum_q - prod_q) > {32'b0, r_q})
					r_q <= r_q + 1'b1;
			end
			ST_AL_DIV: begin
				if (!thr_ord)
					alpha_q <= (r_q > {16'b0, lo_q}) ? ONE_Q16 : '0;
			end
			ST_AL_WAIT: begin
				if (div_sts.done)
					alpha_q <= div_quot[16:0];
			end
			// full-scale alpha overflows the 32-bit square, take it directly
			ST_SM_RND: smooth_q <= (alpha_q == ONE_Q16) ? ONE_Q16 : sm_round[48:32];
			ST_GN_ADD: gain_res_q <= span[16] ? (floor_q - gq[31:16]) : (floor_q + gq[31:16]);
			ST_FIN: begin
				if (out_free) begin
					ok_q    <= ok_res_q;
					gain_q  <= ok_res_q ? gain_res_q : '0;
					acc_x_q <= ok_res_q ? fx_q : '0;
					acc_y_q <= ok_res_q ? fy_q : '0;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign ok        = ok_q;
	assign gain      = gain_q;
	assign accel_x   = acc_x_q;
	assign accel_y   = acc_y_q;

	`ASG_ASSERT_IMP(a_zero_step_out, out_valid && !ok, gain == '0 && accel_x == '0 && accel_y == '0, "rejected sample carries nonzero payload")
	`ASG_ASSERT_IMP(a_div_idle_start, div_start, !div_sts.busy, "divider started while busy")
	`ASG_ASSERT_IMP(a_sqrt_idle_start, sq_start, !sq_sts.busy, "root unit started while busy")
	`ASG_ASSERT_NXT(a_restart_clears, in_valid && !in_stall && func, !primed_q && fx_q == '0 && fy_q == '0, "restart left state behind")

endmodule

[tb/sv/tb_accel_scheduled_gain.sv]
// ----------------------------------------------------------------------------
// tb_accel_scheduled_gain
// self-checking bench for the acceleration scheduled gain block: a bit-exact
// predictor follows every accepted sample through differentiation, norm
// limiting, filtering and the smoothstep gain ramp, and each output
// transaction is compared field by field against the oldest prediction
// ----------------------------------------------------------------------------
module tb_accel_scheduled_gain;
	timeunit 1ns;
	timeprecision 1ps;

	import asg_pkg::*;

	localparam int STALL_LIMIT = 5000;
	localparam int HOLD_CYCLES = 300;
	localparam logic [2:0] REG_SPARE_LO = 3'd6;
	localparam logic [2:0] REG_SPARE_HI = 3'd7;
	localparam logic FUNC_SAMPLE  = 1'b0;
	localparam logic FUNC_RESTART = 1'b1;

	typedef struct {
		logic               ok;
		logic [15:0]        gain;
		logic signed [16:0] ax;
		logic signed [16:0] ay;
	} gain_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               func = 1'b0;
	logic signed [15:0] vel_x = '0;
	logic signed [15:0] vel_y = '0;
	logic [19:0]        step_us = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic               ok;
	logic [15:0]        gain;
	logic signed [16:0] accel_x;
	logic signed [16:0] accel_y;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [2:0]         cfg_index = '0;
	logic [16:0]        cfg_data = '0;

	accel_scheduled_gain dut (.*);

	always #5 clk = ~clk;

	// predictor copy of the registers and the filter state
	longint floor_q12, ceil_q12, low_thr, high_thr, norm_limit, iir_weight;
	longint prev_vx, prev_vy, filt_x, filt_y;
	bit     primed;

	gain_result_t expected_gains[$];
	int  mismatches = 0;
	int  send_idle = 0;
	int  recv_idle = 0;
	int  idle_cycles = 0;
	int  hold_cnt = 0;
	bit  hold_tgl = 1'b0;
	bit  hold_seen = 1'b0;
	int  walk_x = 0;
	int  walk_y = 0;

	function automatic longint round_div(longint num, longint den);
		longint mag, q;
		mag = (num < 0) ? -num : num;
		q = (mag + den / 2) / den;
		return (num < 0) ? -q : q;
	endfunction

	function automatic longint int_sqrt(longint unsigned n);
		longint unsigned r, t;
		r = 0;
		for (int b = 31; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (t * t <= n)
				r = t;
		end
		return longint'(r);
	endfunction

	function automatic longint clip17(longint v);
		if (v > 65535)
			return 65535;
		if (v < -65536)
			return -65536;
		return v;
	endfunction

	function automatic logic [15:0] gain_for_filter();
		longint n2, r, alpha, smooth, width, t, span, g;
		n2 = filt_x * filt_x + filt_y * filt_y;
		r = int_sqrt(n2);
		if (n2 - r * r > r)
			r++;
		if (high_thr <= low_thr) begin
			alpha = (r > low_thr) ? longint'(ONE_Q16) : 0;
		end else begin
			width = high_thr - low_thr;
			t = (r > low_thr) ? r - low_thr : 0;
			if (t > width)
				t = width;
			alpha = (t * longint'(ONE_Q16) + width / 2) / width;
		end
		smooth = (alpha * alpha * (3 * longint'(ONE_Q16) - 2 * alpha) + (64'd1 << 31)) >>> 32;
		span = ceil_q12 - floor_q12;
		g = floor_q12 + round_div(smooth * span, longint'(ONE_Q16));
		return g[15:0];
	endfunction

	function automatic void predict_gain_result(input logic f, input logic signed [15:0] vx,
			input logic signed [15:0] vy, input logic [19:0] st,
			output bit has_res, output gain_result_t res);
		longint rx, ry, ax, ay, r, sx, sy, w;
		bit over;
		has_res = 1'b0;
		res = '{1'b0, '0, '0, '0};
		if (f == FUNC_RESTART) begin
			prev_vx = 0; prev_vy = 0; filt_x = 0; filt_y = 0; primed = 1'b0;
			return;
		end
		has_res = 1'b1;
		if (st == 0)
			return;
		if (!primed) begin
			prev_vx = vx; prev_vy = vy; filt_x = 0; filt_y = 0; primed = 1'b1;
		end else begin
			rx = round_div((longint'(vx) - prev_vx) * longint'(US_PER_S), longint'(st));
			ry = round_div((longint'(vy) - prev_vy) * longint'(US_PER_S), longint'(st));
			ax = (rx < 0) ? -rx : rx;
			ay = (ry < 0) ? -ry : ry;
			over = 1'b0;
			w = (iir_weight > longint'(ONE_Q16)) ? longint'(ONE_Q16) : iir_weight;
			while (ax >= (64'd1 << 31) || ay >= (64'd1 << 31)) begin
				ax = ax >>> 1; ay = ay >>> 1; over = 1'b1;
			end
			if (!over)
				over = ax * ax + ay * ay > norm_limit * norm_limit;
			if (over) begin
				r = int_sqrt(ax * ax + ay * ay);
				sx = 0; sy = 0;
				if (r != 0) begin
					sx = (ax * norm_limit + r / 2) / r;
					sy = (ay * norm_limit + r / 2) / r;
				end
				rx = (rx < 0) ? -sx : sx;
				ry = (ry < 0) ? -sy : sy;
			end
			prev_vx = vx; prev_vy = vy;
			filt_x = clip17(filt_x + round_div(w * (rx - filt_x), longint'(ONE_Q16)));
			filt_y = clip17(filt_y + round_div(w * (ry - filt_y), longint'(ONE_Q16)));
		end
		res.ok = 1'b1;
		res.gain = gain_for_filter();
		res.ax = filt_x[16:0];
		res.ay = filt_y[16:0];
	endfunction

	// output side: check each transaction, stall at random or hold off on request
	always @(posedge clk) begin
		gain_result_t exp_res;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_gains.size() == 0) begin
				$error("unexpected result transaction");
				mismatches++;
			end else begin
				exp_res = expected_gains.pop_front();
				if (ok !== exp_res.ok) begin
					$error("ok expected %0d actual %0d", exp_res.ok, ok);
					mismatches++;
				end
				if (gain !== exp_res.gain) begin
					$error("gain expected %0d actual %0d", exp_res.gain, gain);
					mismatches++;
				end
				if (accel_x !== exp_res.ax) begin
					$error("accel_x expected %0d actual %0d", exp_res.ax, accel_x);
					mismatches++;
				end
				if (accel_y !== exp_res.ay) begin
					$error("accel_y expected %0d actual %0d", exp_res.ay, accel_y);
					mismatches++;
				end
			end
		end
		if (hold_tgl != hold_seen) begin
			hold_seen <= hold_tgl;
			hold_cnt <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= (recv_idle > 0) && ($urandom_range(99) < recv_idle);
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("tb_accel_scheduled_gain NOT OK");
			$finish;
		end
	end

	task automatic send_item(input logic f, input int vx, input int vy, input int st);
		bit has_res;
		gain_result_t res;
		@(posedge clk);
		while (send_idle > 0 && $urandom_range(99) < send_idle)
			@(posedge clk);
		func <= f;
		vel_x <= vx[15:0];
		vel_y <= vy[15:0];
		step_us <= st[19:0];
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		in_valid <= 1'b0;
		predict_gain_result(f, vx[15:0], vy[15:0], st[19:0], has_res, res);
		if (has_res)
			expected_gains.push_back(res);
	endtask

	task automatic wait_idle();
		while (expected_gains.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input int data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data[16:0];
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_GAIN_FLOOR:   floor_q12 = data & 16'hFFFF;
			REG_GAIN_CEILING: ceil_q12 = data & 16'hFFFF;
			REG_LOW_THRESH:   low_thr = data & 16'hFFFF;
			REG_HIGH_THRESH:  high_thr = data & 16'hFFFF;
			REG_ACCEL_LIMIT:  norm_limit = data & 16'hFFFF;
			REG_FILT_WEIGHT:  iir_weight = data & 17'h1FFFF;
			default: ;
		endcase
	endtask

	task automatic apply_settings(input int fl, input int ce, input int lo, input int hi,
			input int lim, input int w);
		wait_idle();
		write_reg(REG_GAIN_FLOOR, fl);
		write_reg(REG_GAIN_CEILING, ce);
		write_reg(REG_LOW_THRESH, lo);
		write_reg(REG_HIGH_THRESH, hi);
		write_reg(REG_ACCEL_LIMIT, lim);
		write_reg(REG_FILT_WEIGHT, w);
	endtask

	task automatic test_corner_samples();
		send_item(FUNC_RESTART, 0, 0, 0);
		send_item(FUNC_SAMPLE, 100, -100, 0);
		send_item(FUNC_SAMPLE, 32767, -32768, 1000);
		send_item(FUNC_SAMPLE, 32767, -32768, 0);
		send_item(FUNC_SAMPLE, -32768, 32767, 1);
		send_item(FUNC_SAMPLE, -32768, 32767, 1048575);
		send_item(FUNC_SAMPLE, 0, 0, 1048575);
		send_item(FUNC_RESTART, -1, -1, 1048575);
		send_item(FUNC_SAMPLE, 0, 0, 10000);
	endtask

	task automatic test_gain_ramp();
		apply_settings(0, 65535, 256, 768, 2560, 65536);
		send_item(FUNC_RESTART, 0, 0, 0);
		send_item(FUNC_SAMPLE, 0, 0, 10000);
		for (int i = 1; i <= 6; i++)
			send_item(FUNC_SAMPLE, i * i * 3, -i * 5, 100000);
		send_item(FUNC_SAMPLE, 2000, 2000, 100000);
	endtask

	task automatic test_register_edges();
		// ceiling below floor, unordered thresholds, zero limit, zero weight
		apply_settings(65535, 0, 1000, 1000, 0, 0);
		write_reg(REG_SPARE_LO, 131071);
		write_reg(REG_SPARE_HI, 12345);
		send_item(FUNC_SAMPLE, 500, 500, 20000);
		send_item(FUNC_SAMPLE, -500, 300, 20000);
		apply_settings(65535, 0, 1000, 1000, 0, 131071);
		send_item(FUNC_SAMPLE, 3000, -3000, 10000);
		send_item(FUNC_SAMPLE, 3000, -3000, 10000);
		apply_settings(1, 65534, 0, 65535, 65535, 1);
		send_item(FUNC_SAMPLE, -32768, 32767, 3);
		send_item(FUNC_SAMPLE, 32767, -32768, 7);
	endtask

	task automatic random_settings();
		int lo, hi;
		lo = $urandom_range(0, 3000);
		hi = ($urandom_range(9) == 0) ? $urandom_range(0, lo) : lo + $urandom_range(1, 6000);
		apply_settings($urandom_range(0, 65535), $urandom_range(0, 65535), lo, hi,
			($urandom_range(4) == 0) ? $urandom_range(1, 65535) : $urandom_range(300, 6000),
			($urandom_range(5) == 0) ? $urandom_range(65536, 131071) : $urandom_range(1, 65536));
	endtask

	task automatic test_random_traffic(input int n_items, input int s_idle, input int r_idle);
		int pick, st;
		random_settings();
		@(posedge clk);
		send_idle <= s_idle;
		recv_idle <= r_idle;
		for (int i = 0; i < n_items; i++) begin
			pick = $urandom_range(99);
			if (pick < 5) begin
				send_item(FUNC_RESTART, $urandom_range(0, 65535), $urandom_range(0, 65535),
					$urandom_range(0, 1048575));
				walk_x = 0;
				walk_y = 0;
			end else if (pick < 10) begin
				send_item(FUNC_SAMPLE, $urandom_range(0, 65535), $urandom_range(0, 65535), 0);
			end else begin
				if ($urandom_range(9) == 0) begin
					walk_x = int'($urandom_range(0, 65535)) - 32768;
					walk_y = int'($urandom_range(0, 65535)) - 32768;
				end else begin
					walk_x += int'($urandom_range(0, 600)) - 300;
					walk_y += int'($urandom_range(0, 600)) - 300;
					if (walk_x > 32767) walk_x = 32767;
					if (walk_x < -32768) walk_x = -32768;
					if (walk_y > 32767) walk_y = 32767;
					if (walk_y < -32768) walk_y = -32768;
				end
				pick = $urandom_range(9);
				st = (pick < 7) ? $urandom_range(5000, 50000) :
					(pick < 9) ? $urandom_range(1, 1048575) : $urandom_range(1, 100);
				send_item(FUNC_SAMPLE, walk_x, walk_y, st);
			end
		end
	endtask

	task automatic test_back_pressure();
		wait_idle();
		send_idle <= 0;
		recv_idle <= 0;
		hold_tgl <= ~hold_tgl;
		for (int i = 0; i < 12; i++)
			send_item(FUNC_SAMPLE, i * 400 - 2000, 1500 - i * 300, 20000);
	endtask

	initial begin
		floor_q12 = 4096; ceil_q12 = 4096; low_thr = 256; high_thr = 768;
		norm_limit = 2560; iir_weight = 65536;
		prev_vx = 0; prev_vy = 0; filt_x = 0; filt_y = 0; primed = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		test_corner_samples();
		test_gain_ramp();
		test_register_edges();
		test_random_traffic(200, 26, 45);
		test_random_traffic(200, 45, 26);
		test_random_traffic(200, 0, 0);
		test_back_pressure();
		wait_idle();
		repeat (400) @(posedge clk);
		if (mismatches == 0 && expected_gains.size() == 0) begin
			$display("tb_accel_scheduled_gain OK");
		end else begin
			$display("tb_accel_scheduled_gain NOT OK");
		end
		$finish;
	end

endmodule
